// ----- design/assert_macros.svh -----
// Assertion helpers shared by the design files.
// Every check is sampled on clk and is held off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define TDFD_ASSERT(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");
`define TDFD_ASSERT_NEXT(label, trig, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error("assertion failed");
`else
`define TDFD_ASSERT(label, cond)
`define TDFD_ASSERT_NEXT(label, trig, cond)
`endif
`endif

// ----- design/tdfd_pkg.sv -----
`timescale 1ns / 1ps
package tdfd_pkg;

  localparam int TILE_EDGE  = 64;
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  // Tile edge and frame maxima are powers of two: tile position is a shift and
  // the frame store address is the row and column side by side.
  localparam int TILE_SHIFT = $clog2(TILE_EDGE);
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int WD_W       = COL_W + 1;
  localparam int HD_W       = ROW_W + 1;
  localparam int ADDR_W     = ROW_W + COL_W;

  localparam int MAX_ACROSS = (MAX_WIDTH + TILE_EDGE - 1) / TILE_EDGE;
  localparam int MAX_DOWN   = (MAX_HEIGHT + TILE_EDGE - 1) / TILE_EDGE;
  localparam int ACR_W      = $clog2(MAX_ACROSS + 1);
  localparam int DWN_W      = $clog2(MAX_DOWN + 1);
  localparam int GRID_W     = ACR_W + DWN_W + 1;

  localparam int TILE_SLOTS = 256;
  localparam int SLOT_W     = $clog2(TILE_SLOTS);
  localparam int CNT_W      = $clog2(TILE_SLOTS + 1);

  localparam int CFG_W      = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int PIX_W      = 32;
  localparam int OP_W       = 2;

  localparam logic [OP_W-1:0] OP_PIXEL = 2'd0;
  localparam logic [OP_W-1:0] OP_FORCE = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ALWAYS_FULL  = 2'd2;

  // One item held in the compare stage.
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [PIX_W-1:0]  pixel;
    logic [SLOT_W-1:0] slot;
    logic              tile_ok;
    logic [ADDR_W-1:0] addr;
    logic              start;
    logic              last;
  } stage_t;

endpackage

// ----- design/tdfd_frame_ram.sv -----
`timescale 1ns / 1ps
module tdfd_frame_ram #(
  parameter int ADDR_W = 20,
  parameter int DATA_W = 32
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- design/tile_dirty_frame_diff.sv -----
`timescale 1ns / 1ps
// Throughput: one transaction per cycle unless a result waiting for out_tready stalls the
// compare stage; set by the single read-modify-write of the frame store (read at acceptance,
// compare and write back when the item leaves the compare stage, with forwarding).
// Reset: synchronous, active low; clears counters, tile flags and frame marks at once.
// The frame store itself is not cleared: no entry is compared before a full frame is stored.
`include "assert_macros.svh"
module tile_dirty_frame_diff (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: pixel_value[31:0], tile_number[39:32]
  input  logic [39:0] in_tdata,
  // in_tuser: op[1:0]
  input  logic [1:0]  in_tuser,
  input  logic        in_tvalid,
  output logic        in_tready,
  // out_tdata: dirty_tiles[8:0], was_full[9], tile_flag[10], zero[15:11]
  output logic [15:0] out_tdata,
  output logic        out_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_wdata
);

  localparam int WCMP = (tdfd_pkg::CFG_W > tdfd_pkg::WD_W) ? tdfd_pkg::CFG_W : tdfd_pkg::WD_W;
  localparam int HCMP = (tdfd_pkg::CFG_W > tdfd_pkg::HD_W) ? tdfd_pkg::CFG_W : tdfd_pkg::HD_W;

  // Configuration
  logic [tdfd_pkg::CFG_W-1:0] cfg_width_r, cfg_height_r;
  logic                       always_full_r;
  logic                       size_wr;

  // Frame position and frame marks
  logic [tdfd_pkg::COL_W-1:0] col_r, col_nxt;
  logic [tdfd_pkg::ROW_W-1:0] row_r, row_nxt;
  logic                       has_content_r, has_content_nxt;
  logic                       force_r, force_nxt;
  logic                       full_r, full_nxt;
  logic [tdfd_pkg::CNT_W-1:0] full_tiles_r, full_tiles_nxt;
  logic [tdfd_pkg::CNT_W-1:0] dirty_cnt_r, dirty_cnt_nxt;
  logic [tdfd_pkg::TILE_SLOTS-1:0] flags_r, flags_nxt;

  // Compare stage and forwarding
  logic                       s1_valid_r;
  tdfd_pkg::stage_t           s1_r, s1_nxt;
  logic                       fwd_r;
  logic [tdfd_pkg::PIX_W-1:0] fwd_data_r;
  logic [tdfd_pkg::PIX_W-1:0] ram_rd_data;

  // Output register
  logic        out_valid_r;
  logic [15:0] out_data_r;
  logic        out_last_r;

  // Derived sizes
  logic [WCMP-1:0]              w_raw;
  logic [HCMP-1:0]              h_raw;
  logic [tdfd_pkg::WD_W-1:0]    eff_w;
  logic [tdfd_pkg::HD_W-1:0]    eff_h;
  logic [tdfd_pkg::WD_W:0]      w_round;
  logic [tdfd_pkg::HD_W:0]      h_round;
  logic [tdfd_pkg::ACR_W-1:0]   tiles_across;
  logic [tdfd_pkg::DWN_W-1:0]   tiles_down;
  logic [tdfd_pkg::GRID_W-1:0]  grid_tiles;
  logic [tdfd_pkg::CNT_W-1:0]   tile_count;

  // Acceptance path
  logic                         in_acc;
  logic                         wrap;
  logic [tdfd_pkg::COL_W-1:0]   colx;
  logic [tdfd_pkg::ROW_W-1:0]   rowx;
  logic                         last_col, last_row;
  logic [tdfd_pkg::GRID_W-1:0]  tile_idx;
  logic [tdfd_pkg::ADDR_W-1:0]  rd_addr;
  logic                         is_pixel_in;

  // Retire path
  logic                         s1_has_result;
  logic                         s1_retire;
  logic                         s1_write;
  logic [tdfd_pkg::PIX_W-1:0]   prev_pixel;
  logic                         full_cur;
  logic                         res_done, res_full, res_flag;
  logic [tdfd_pkg::CNT_W-1:0]   res_cnt;

  always_comb begin
    w_raw = WCMP'(cfg_width_r);
    h_raw = HCMP'(cfg_height_r);
    if (w_raw == '0) begin
      eff_w = tdfd_pkg::WD_W'(1);
    end else if (w_raw > WCMP'(tdfd_pkg::MAX_WIDTH)) begin
      eff_w = tdfd_pkg::WD_W'(tdfd_pkg::MAX_WIDTH);
    end else begin
      eff_w = tdfd_pkg::WD_W'(w_raw);
    end
    if (h_raw == '0) begin
      eff_h = tdfd_pkg::HD_W'(1);
    end else if (h_raw > HCMP'(tdfd_pkg::MAX_HEIGHT)) begin
      eff_h = tdfd_pkg::HD_W'(tdfd_pkg::MAX_HEIGHT);
    end else begin
      eff_h = tdfd_pkg::HD_W'(h_raw);
    end
    w_round      = {1'b0, eff_w} + (tdfd_pkg::WD_W + 1)'(tdfd_pkg::TILE_EDGE - 1);
    h_round      = {1'b0, eff_h} + (tdfd_pkg::HD_W + 1)'(tdfd_pkg::TILE_EDGE - 1);
    tiles_across = tdfd_pkg::ACR_W'(w_round >> tdfd_pkg::TILE_SHIFT);
    tiles_down   = tdfd_pkg::DWN_W'(h_round >> tdfd_pkg::TILE_SHIFT);
    grid_tiles   = tdfd_pkg::GRID_W'(tiles_across) * tdfd_pkg::GRID_W'(tiles_down);
    if (grid_tiles > tdfd_pkg::GRID_W'(tdfd_pkg::TILE_SLOTS)) begin
      tile_count = tdfd_pkg::CNT_W'(tdfd_pkg::TILE_SLOTS);
    end else begin
      tile_count = tdfd_pkg::CNT_W'(grid_tiles);
    end
  end

  // A write of either frame dimension restarts the frame and forces the next one full.
  assign size_wr = cfg_wr_en && ((cfg_index == tdfd_pkg::REG_FRAME_WIDTH) ||
                                 (cfg_index == tdfd_pkg::REG_FRAME_HEIGHT));

  // The compare stage may retire into the output register whenever that register is free
  // or is being emptied, so one transaction can be accepted while a result waits.
  assign s1_has_result = s1_valid_r && ((s1_r.op == tdfd_pkg::OP_QUERY) ||
                         ((s1_r.op == tdfd_pkg::OP_PIXEL) && s1_r.last));
  assign s1_retire = s1_valid_r && (!s1_has_result || !out_valid_r || out_tready);
  assign s1_write  = s1_retire && (s1_r.op == tdfd_pkg::OP_PIXEL);
  assign in_tready = !s1_valid_r || s1_retire;
  assign in_acc    = in_tvalid && in_tready;
  assign is_pixel_in = (in_tuser == tdfd_pkg::OP_PIXEL);

  always_comb begin
    wrap = ({1'b0, col_r} >= eff_w) || ({1'b0, row_r} >= eff_h);
    colx = wrap ? '0 : col_r;
    rowx = wrap ? '0 : row_r;
    last_col = ({1'b0, colx} + tdfd_pkg::WD_W'(1)) >= eff_w;
    last_row = ({1'b0, rowx} + tdfd_pkg::HD_W'(1)) >= eff_h;
    tile_idx = tdfd_pkg::GRID_W'(rowx >> tdfd_pkg::TILE_SHIFT) * tdfd_pkg::GRID_W'(tiles_across)
             + tdfd_pkg::GRID_W'(colx >> tdfd_pkg::TILE_SHIFT);
    rd_addr  = {rowx, colx};

    s1_nxt.op      = in_tuser;
    s1_nxt.pixel   = in_tdata[31:0];
    s1_nxt.slot    = is_pixel_in ? tile_idx[tdfd_pkg::SLOT_W-1:0] : in_tdata[39:32];
    s1_nxt.tile_ok = tile_idx < tdfd_pkg::GRID_W'(tdfd_pkg::TILE_SLOTS);
    s1_nxt.addr    = rd_addr;
    s1_nxt.start   = (colx == '0) && (rowx == '0);
    s1_nxt.last    = last_col && last_row;

    col_nxt = col_r;
    row_nxt = row_r;
    if (in_acc && is_pixel_in) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : rowx + tdfd_pkg::ROW_W'(1);
      end else begin
        col_nxt = colx + tdfd_pkg::COL_W'(1);
        row_nxt = rowx;
      end
    end
    if (size_wr) begin
      col_nxt = '0;
      row_nxt = '0;
    end
  end

  tdfd_frame_ram #(
    .ADDR_W (tdfd_pkg::ADDR_W),
    .DATA_W (tdfd_pkg::PIX_W)
  ) u_frame_ram (
    .clk     (clk),
    .wr_en   (s1_write),
    .wr_addr (s1_r.addr),
    .wr_data (s1_r.pixel),
    .rd_en   (in_acc && is_pixel_in),
    .rd_addr (rd_addr),
    .rd_data (ram_rd_data)
  );

  // A read that hits the entry being written in the same cycle gets the old word from
  // the memory, so the new pixel is carried forward instead.
  assign prev_pixel = fwd_r ? fwd_data_r : ram_rd_data;

  always_comb begin
    has_content_nxt = has_content_r;
    force_nxt       = force_r;
    full_nxt        = full_r;
    full_tiles_nxt  = full_tiles_r;
    dirty_cnt_nxt   = dirty_cnt_r;
    flags_nxt       = flags_r;
    full_cur        = full_r;
    res_done        = 1'b0;
    res_full        = 1'b0;
    res_flag        = 1'b0;
    res_cnt         = '0;
    if (s1_retire) begin
      unique case (s1_r.op)
        tdfd_pkg::OP_FORCE: begin
          force_nxt = 1'b1;
        end
        tdfd_pkg::OP_QUERY: begin
          if (full_r) begin
            res_flag = {1'b0, s1_r.slot} < full_tiles_r;
          end else begin
            res_flag = flags_r[s1_r.slot];
          end
        end
        tdfd_pkg::OP_PIXEL: begin
          if (s1_r.start) begin
            flags_nxt = '0;
            full_cur  = !has_content_r || force_r || always_full_r;
            full_nxt  = full_cur;
            if (full_cur) begin
              force_nxt      = 1'b0;
              dirty_cnt_nxt  = tile_count;
              full_tiles_nxt = tile_count;
            end else begin
              dirty_cnt_nxt = '0;
            end
          end
          if (!full_cur && (prev_pixel != s1_r.pixel) && s1_r.tile_ok &&
              !flags_nxt[s1_r.slot]) begin
            flags_nxt[s1_r.slot] = 1'b1;
            dirty_cnt_nxt        = dirty_cnt_nxt + tdfd_pkg::CNT_W'(1);
          end
          if (s1_r.last) begin
            has_content_nxt = 1'b1;
            res_done        = 1'b1;
            res_full        = full_cur;
            res_cnt         = dirty_cnt_nxt;
          end
        end
        default: begin
        end
      endcase
    end
    if (size_wr) begin
      force_nxt       = 1'b1;
      has_content_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_width_r   <= tdfd_pkg::CFG_W'(1024);
      cfg_height_r  <= tdfd_pkg::CFG_W'(1024);
      always_full_r <= 1'b0;
      col_r         <= '0;
      row_r         <= '0;
      has_content_r <= 1'b0;
      force_r       <= 1'b0;
      full_r        <= 1'b0;
      full_tiles_r  <= '0;
      dirty_cnt_r   <= '0;
      flags_r       <= '0;
      s1_valid_r    <= 1'b0;
      fwd_r         <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      col_r         <= col_nxt;
      row_r         <= row_nxt;
      has_content_r <= has_content_nxt;
      force_r       <= force_nxt;
      full_r        <= full_nxt;
      full_tiles_r  <= full_tiles_nxt;
      dirty_cnt_r   <= dirty_cnt_nxt;
      flags_r       <= flags_nxt;
      if (in_acc) begin
        s1_valid_r <= 1'b1;
        fwd_r      <= s1_write && (s1_r.addr == rd_addr);
      end else if (s1_retire) begin
        s1_valid_r <= 1'b0;
        fwd_r      <= 1'b0;
      end
      if (s1_retire && s1_has_result) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      // Config writes must arrive only while no transaction is in flight; the block itself does not enforce this.
      if (cfg_wr_en) begin
        unique case (cfg_index)
          tdfd_pkg::REG_FRAME_WIDTH: begin
            cfg_width_r <= cfg_wdata;
          end
          tdfd_pkg::REG_FRAME_HEIGHT: begin
            cfg_height_r <= cfg_wdata;
          end
          tdfd_pkg::REG_ALWAYS_FULL: begin
            always_full_r <= cfg_wdata[0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_r       <= s1_nxt;
      fwd_data_r <= s1_r.pixel;
    end
    if (s1_retire && s1_has_result) begin
      out_data_r <= {5'd0, res_flag, res_full, res_cnt};
      out_last_r <= res_done;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  `TDFD_ASSERT(a_dirty_cnt_range, dirty_cnt_r <= tdfd_pkg::CNT_W'(tdfd_pkg::TILE_SLOTS))
  `TDFD_ASSERT(a_fwd_needs_item, !fwd_r || s1_valid_r)
  `TDFD_ASSERT(a_frame_end_no_flag, !(out_valid_r && out_last_r) || !out_data_r[10])
  `TDFD_ASSERT_NEXT(a_hold_on_stall, s1_valid_r && !s1_retire, s1_valid_r && $stable(s1_r))

endmodule
